@@ hdl/apfp_pkg.sv @@
// Shared types and constants for the receive-packet API frame parser.
// No dependencies; imported by every module of the block.
package apfp_pkg;

  // Byte positions within a frame
  localparam int unsigned PosW         = 17;
  localparam int unsigned LenHiPos     = 1;
  localparam int unsigned LenLoPos     = 2;
  localparam int unsigned SumFirstPos  = 3;
  localparam int unsigned SrcFirstPos  = 4;
  localparam int unsigned SrcBytes     = 8;
  localparam int unsigned NetHiPos     = 12;
  localparam int unsigned NetLoPos     = 13;
  localparam int unsigned OptPos       = 14;
  localparam int unsigned DataFirstPos = 15;

  // Length field counts from the frame-type byte; below this it means "to the end"
  localparam int unsigned LenShortLimit = 12;
  localparam int unsigned LenBias       = 3;

  localparam logic [7:0] SumGood = 8'hFF;

  // Output word layout
  localparam int unsigned OutDataW = 120;

  typedef enum logic {
    KindData    = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic [63:0] source_address;
    logic [15:0] network_address;
    logic [7:0]  receive_options;
    logic        checksum_ok;
    logic        too_short;
  } result_t;

endpackage

@@ hdl/api_rx_packet_frame_parser.sv @@
// Top level of the receive-packet API frame parser.
// Depends on apfp_pkg, apfp_front, apfp_fifo and apfp_back.
//
// Usage:
//   Slave stream: one frame byte per word in s_axis_tdata_i[7:0]; s_axis_tlast_i
//   marks the final byte of a frame. Header bytes (length, 64-bit source, 16-bit
//   network address, options) are captured by position; bytes from position 15
//   within the length window come out as data words.
//   Master stream: m_axis_tuser_o = 0 for a data word, 1 for the end-of-frame
//   summary carrying the header fields, checksum flag and short-frame flag.
//   A byte that produces nothing (header, padding past the length) is absorbed.
// Path: a result enters the queue at the edge that accepts its byte, then
//   moves into the output register once that register is empty or being read.
// Throughput: one byte per cycle while the queue has room; the byte counter
//   and header registers update in the accepting cycle and never hold input.
// Stall: when m_axis_tready_i is low, results collect in the FifoDepth-entry
//   queue plus the output register; s_axis_tready_o drops only when the queue
//   is full, and rises again the cycle after a word leaves.
// Reset: rst_ni clears the byte counter, header captures and checksum to zero,
//   empties the queue and drops m_axis_tvalid_o. No clearing pass is needed.
module api_rx_packet_frame_parser #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  input  logic         s_axis_tlast_i,   // end_of_frame
  // master stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o,   // [7:0] data_byte, [23:8] frame_length,
                                         // [87:24] source_address,
                                         // [103:88] network_address,
                                         // [111:104] receive_options,
                                         // [112] checksum_ok, [113] too_short,
                                         // [119:114] zero
  output logic         m_axis_tuser_o    // kind: 0 data word, 1 frame summary
);
  import apfp_pkg::*;

  logic    fifo_full, fifo_empty;
  logic    push, pop;
  result_t front_res, fifo_res;

  assign s_axis_tready_o = ~fifo_full;

  // Front: position tracking, header capture, checksum, result build
  apfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_i (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .push_o     (push),
    .result_o   (front_res)
  );

  // Decoupling queue: front never waits on the receiver until it fills
  apfp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_res),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .data_o  (fifo_res),
    .empty_o (fifo_empty)
  );

  // Back: registered master stream
  apfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (~fifo_empty),
    .result_i    (fifo_res),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

@@ hdl/apfp_front.sv @@
// Front end: byte counter, header capture and checksum; builds one result per word.
// Depends on apfp_pkg.
module apfp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             push_o,
  output apfp_pkg::result_t result_o
);
  import apfp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  logic [63:0]     src_q, src_d;
  logic [15:0]     net_q, net_d;
  logic [7:0]      opt_q, opt_d;
  logic [7:0]      sum_q, sum_d;
  logic            accept;
  logic            data_hit;
  logic [PosW-1:0] len_end;

  assign accept  = in_valid_i & in_ready_i;
  assign len_end = {1'b0, len_q} + PosW'(LenBias);

  // Header capture and checksum: the word lands in its field and adds to the sum
  always_comb begin
    len_d = len_q;
    src_d = src_q;
    net_d = net_q;
    opt_d = opt_q;
    sum_d = sum_q;
    priority if (pos_q == PosW'(LenHiPos)) begin
      len_d[15:8] = in_byte_i;
    end else if (pos_q == PosW'(LenLoPos)) begin
      len_d[7:0] = in_byte_i;
    end else if (pos_q == PosW'(NetHiPos)) begin
      net_d[15:8] = in_byte_i;
    end else if (pos_q == PosW'(NetLoPos)) begin
      net_d[7:0] = in_byte_i;
    end else if (pos_q == PosW'(OptPos)) begin
      opt_d = in_byte_i;
    end else begin
      for (int i = 0; i < SrcBytes; i++) begin
        if (pos_q == PosW'(SrcFirstPos + i)) begin
          src_d[(SrcBytes-1-i)*8 +: 8] = in_byte_i;
        end
      end
    end
    if (pos_q >= PosW'(SumFirstPos)) begin
      sum_d = sum_q + in_byte_i;
    end
  end

  assign data_hit = (pos_q >= PosW'(DataFirstPos)) &&
                    ((len_q < 16'(LenShortLimit)) || (pos_q < len_end));

  always_comb begin
    result_o = '0;
    if (in_last_i) begin
      result_o.kind            = KindSummary;
      result_o.frame_length    = len_d;
      result_o.source_address  = src_d;
      result_o.network_address = net_d;
      result_o.receive_options = opt_d;
      result_o.checksum_ok     = (sum_d == SumGood);
      result_o.too_short       = (pos_q < PosW'(DataFirstPos));
    end else begin
      result_o.kind      = KindData;
      result_o.data_byte = in_byte_i;
    end
  end

  assign push_o = accept & (in_last_i | data_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      src_q <= '0;
      net_q <= '0;
      opt_q <= '0;
      sum_q <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        pos_q <= '0;
        len_q <= '0;
        src_q <= '0;
        net_q <= '0;
        opt_q <= '0;
        sum_q <= '0;
      end else begin
        if (pos_q != '1) pos_q <= pos_q + PosW'(1);
        len_q <= len_d;
        src_q <= src_d;
        net_q <= net_d;
        opt_q <= opt_d;
        sum_q <= sum_d;
      end
    end
  end

endmodule

@@ hdl/apfp_fifo.sv @@
// Short result queue between the parser front end and the output stage.
// Depends on apfp_pkg for the result type.
module apfp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  apfp_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output apfp_pkg::result_t data_o,
  output logic              empty_o
);
  import apfp_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  result_t          mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
      if (do_pop)  rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

@@ hdl/apfp_back.sv @@
// Back end: output register for the master stream, packs a result into a word.
// Depends on apfp_pkg.
module apfp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  apfp_pkg::result_t       result_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [apfp_pkg::OutDataW-1:0] out_data_o,
  output logic                    out_user_o
);
  import apfp_pkg::*;

  localparam int unsigned PackW = 114;

  logic                valid_q;
  logic [OutDataW-1:0] data_q;
  logic                user_q;
  logic [PackW-1:0]    packed_w;

  // lowest bits first: data_byte, frame_length, source, network, options, ok, short
  assign packed_w = {result_i.too_short, result_i.checksum_ok, result_i.receive_options,
                     result_i.network_address, result_i.source_address,
                     result_i.frame_length, result_i.data_byte};

  assign pop_o = avail_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {{(OutDataW-PackW){1'b0}}, packed_w};
      user_q <= result_i.kind;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;

endmodule
